// ----- rtl/abr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abr_pkg
// Shared types, codes and defaults for the audio block ring with frame readout.
// ----------------------------------------------------------------------------
package abr_pkg;

	localparam int BLOCKS_DEF      = 3;
	localparam int BLOCK_PAIRS_DEF = 288;
	localparam int FRAME_PAIRS_DEF = 48;

	localparam int POSITION_W   = 9;
	localparam int SAMPLE_W     = 16;
	localparam int CHANNEL_W    = 8;
	localparam int MUTE_VALUE_W = 8;
	localparam int WORD_W       = 2 * SAMPLE_W;
	localparam int COUNT_W      = 32;

	localparam int MUTE_CHANNELS = 3;
	localparam int MUTE_MASTER   = 0;

	typedef enum logic [2:0] {
		OP_WRITE     = 3'd0,
		OP_COMMIT    = 3'd1,
		OP_FRAME     = 3'd2,
		OP_RESYNC    = 3'd3,
		OP_SET_MUTE  = 3'd4,
		OP_READ_MUTE = 3'd5
	} op_e;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [2:0]                  opcode;
		logic [POSITION_W-1:0]       position;
		logic signed [SAMPLE_W-1:0]  left_in;
		logic signed [SAMPLE_W-1:0]  right_in;
		logic [CHANNEL_W-1:0]        channel;
		logic [MUTE_VALUE_W-1:0]     mute_value;
	} cmd_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic                       last_of_run;
		logic                       mute_status;
	} res_t;

	// one result slot issued by the sequencer, filled from the registered store read
	typedef struct packed {
		logic valid;
		logic use_mem;
		logic last;
		logic mute_status;
	} res_meta_t;

	typedef struct packed {
		logic load;
		logic inc;
	} agen_ctl_t;

endpackage

// ----- rtl/abr_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abr_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface abr_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/abr_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abr_store
// Sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module abr_store #(
	parameter int DEPTH = abr_pkg::BLOCKS_DEF * abr_pkg::BLOCK_PAIRS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [abr_pkg::WORD_W-1:0]  wdata,
	input  logic [AW-1:0]               raddr,
	output logic [abr_pkg::WORD_W-1:0]  rdata
);

	logic [abr_pkg::WORD_W-1:0] mem [DEPTH];
	logic [abr_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/abr_agen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abr_agen
// Shared address unit: one register and incrementer used for the clearing
// sweep and for frame readout, with bound compares.
// ----------------------------------------------------------------------------
module abr_agen #(
	parameter int LIMIT = abr_pkg::BLOCKS_DEF * abr_pkg::BLOCK_PAIRS_DEF,
	parameter int AGW   = $clog2(LIMIT + abr_pkg::FRAME_PAIRS_DEF)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  abr_pkg::agen_ctl_t ctl,
	input  logic [AGW-1:0]     load_val,
	output logic [AGW-1:0]     addr,
	output logic               in_range,
	output logic               at_end
);

	logic [AGW-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (ctl.load) begin
			addr_q <= load_val;
		end else if (ctl.inc) begin
			addr_q <= addr_q + AGW'(1);
		end
	end

	assign addr     = addr_q;
	assign in_range = addr_q < AGW'(LIMIT);
	assign at_end   = addr_q == AGW'(LIMIT - 1);

endmodule

// ----- rtl/abr_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abr_seq
// Command sequencer: ring counters, mute flags, store writes, clearing sweep
// and the per-pair issue loop of a frame request.
// ----------------------------------------------------------------------------
module abr_seq #(
	parameter int BLOCKS      = abr_pkg::BLOCKS_DEF,
	parameter int BLOCK_PAIRS = abr_pkg::BLOCK_PAIRS_DEF,
	parameter int FRAME_PAIRS = abr_pkg::FRAME_PAIRS_DEF,
	parameter int AW          = $clog2(BLOCKS * BLOCK_PAIRS),
	parameter int AGW         = $clog2(BLOCKS * BLOCK_PAIRS + FRAME_PAIRS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  abr_pkg::cmd_t              cmd,
	output logic                       cmd_ready,
	input  logic                       room,
	output abr_pkg::res_meta_t         issue,
	output logic                       we,
	output logic [AW-1:0]              waddr,
	output logic [abr_pkg::WORD_W-1:0] wdata,
	output abr_pkg::agen_ctl_t         agen_ctl,
	output logic [AGW-1:0]             agen_load,
	input  logic [AGW-1:0]             agen_addr,
	input  logic                       agen_in_range,
	input  logic                       agen_at_end
);

	localparam int FRAMES_RAW       = BLOCK_PAIRS / FRAME_PAIRS;
	localparam int FRAMES_PER_BLOCK = (FRAMES_RAW > 0) ? FRAMES_RAW : 1;
	localparam int FW               = (FRAMES_PER_BLOCK > 1) ? $clog2(FRAMES_PER_BLOCK) : 1;
	localparam int SW               = $clog2(BLOCKS);
	localparam int SW1              = SW + 1;
	localparam int CW               = $clog2(FRAME_PAIRS);
	// slot of the count value 2^32, where the counters wrap
	localparam int WRAP_REM = int'((longint'(1) << abr_pkg::COUNT_W) % longint'(BLOCKS));

	abr_pkg::state_t state_q, state_d;

	logic [abr_pkg::COUNT_W-1:0] head_q, tail_q;
	logic [SW-1:0]               head_slot_q, tail_slot_q;
	logic [FW-1:0]               fidx_q;
	logic [abr_pkg::MUTE_CHANNELS-1:0] mute_q;
	logic                        zero_q, advance_q;
	logic [CW-1:0]               cnt_q;

	logic                        accept;
	logic [abr_pkg::COUNT_W-1:0] depth;
	logic                        backlog, empty, pos_ok, last_pair, chan_ok, mute_sel;
	logic [AW-1:0]               wr_addr;
	logic [AGW-1:0]              frame_base;
	logic [SW1-1:0]              wrap_sum;
	logic [SW-1:0]               drop_slot;

	assign accept    = cmd_valid && cmd_ready;
	assign depth     = head_q - tail_q;
	assign backlog   = depth > abr_pkg::COUNT_W'(BLOCKS);
	assign empty     = head_q == tail_q;
	assign pos_ok    = 32'(cmd.position) < 32'(BLOCK_PAIRS);
	assign last_pair = cnt_q == CW'(FRAME_PAIRS - 1);
	assign chan_ok   = cmd.channel < abr_pkg::CHANNEL_W'(abr_pkg::MUTE_CHANNELS);
	assign mute_sel  = chan_ok ? mute_q[cmd.channel[1:0]] : mute_q[abr_pkg::MUTE_MASTER];

	assign wr_addr    = AW'(head_slot_q) * AW'(BLOCK_PAIRS) + AW'(cmd.position);
	assign frame_base = AGW'(tail_slot_q) * AGW'(BLOCK_PAIRS)
	                  + AGW'(fidx_q) * AGW'(FRAME_PAIRS);

	// head minus BLOCKS keeps the head slot unless it wraps below zero
	assign wrap_sum  = SW1'(WRAP_REM) + SW1'(head_slot_q);
	assign drop_slot = (head_q >= abr_pkg::COUNT_W'(BLOCKS)) ? head_slot_q
	                 : (wrap_sum >= SW1'(BLOCKS)) ? SW'(wrap_sum - SW1'(BLOCKS))
	                 : wrap_sum[SW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			abr_pkg::ST_CLEAR: begin
				if (agen_at_end) state_d = abr_pkg::ST_IDLE;
			end
			abr_pkg::ST_IDLE: begin
				if (accept && cmd.opcode == abr_pkg::OP_FRAME) state_d = abr_pkg::ST_PREP;
			end
			abr_pkg::ST_PREP: begin
				state_d = abr_pkg::ST_RUN;
			end
			abr_pkg::ST_RUN: begin
				if (room && last_pair) state_d = abr_pkg::ST_IDLE;
			end
			default: begin
				state_d = abr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		issue     = '0;
		we        = 1'b0;
		waddr     = wr_addr;
		wdata     = {cmd.right_in, cmd.left_in};
		agen_ctl  = '0;
		agen_load = frame_base;
		case (state_q)
			abr_pkg::ST_CLEAR: begin
				we           = 1'b1;
				waddr        = agen_addr[AW-1:0];
				wdata        = '0;
				agen_ctl.inc = 1'b1;
			end
			abr_pkg::ST_IDLE: begin
				cmd_ready = room;
				if (accept && cmd.opcode == abr_pkg::OP_WRITE && pos_ok) begin
					we = 1'b1;
				end
				if (accept && cmd.opcode == abr_pkg::OP_READ_MUTE) begin
					issue.valid       = 1'b1;
					issue.last        = 1'b1;
					issue.mute_status = mute_sel;
				end
			end
			abr_pkg::ST_PREP: begin
				agen_ctl.load = 1'b1;
			end
			abr_pkg::ST_RUN: begin
				if (room) begin
					issue.valid   = 1'b1;
					issue.use_mem = !zero_q && agen_in_range;
					issue.last    = last_pair;
					agen_ctl.inc  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= abr_pkg::ST_CLEAR;
			head_q      <= '0;
			tail_q      <= '0;
			head_slot_q <= '0;
			tail_slot_q <= '0;
			fidx_q      <= '0;
			mute_q      <= '0;
			zero_q      <= 1'b0;
			advance_q   <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == abr_pkg::ST_IDLE && accept) begin
				case (cmd.opcode)
					abr_pkg::OP_COMMIT: begin
						head_q      <= head_q + abr_pkg::COUNT_W'(1);
						head_slot_q <= (head_slot_q == SW'(BLOCKS - 1) || &head_q) ? '0
						             : head_slot_q + SW'(1);
					end
					abr_pkg::OP_FRAME: begin
						// drop the backlog beyond the ring depth
						if (backlog) begin
							tail_q      <= head_q - abr_pkg::COUNT_W'(BLOCKS);
							tail_slot_q <= drop_slot;
							fidx_q      <= '0;
						end
					end
					abr_pkg::OP_RESYNC: begin
						tail_q      <= head_q;
						tail_slot_q <= head_slot_q;
						fidx_q      <= '0;
					end
					abr_pkg::OP_SET_MUTE: begin
						if (chan_ok) mute_q[cmd.channel[1:0]] <= cmd.mute_value != '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == abr_pkg::ST_PREP) begin
				zero_q    <= empty || mute_q[abr_pkg::MUTE_MASTER];
				advance_q <= !empty;
				cnt_q     <= '0;
			end
			if (state_q == abr_pkg::ST_RUN && room) begin
				cnt_q <= cnt_q + CW'(1);
				if (last_pair && advance_q) begin
					if (fidx_q == FW'(FRAMES_PER_BLOCK - 1)) begin
						fidx_q      <= '0;
						tail_q      <= tail_q + abr_pkg::COUNT_W'(1);
						tail_slot_q <= (tail_slot_q == SW'(BLOCKS - 1) || &tail_q) ? '0
						             : tail_slot_q + SW'(1);
					end else begin
						fidx_q <= fidx_q + FW'(1);
					end
				end
			end
		end
	end

endmodule

// ----- rtl/audio_block_ring_with_frame_readout.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_block_ring_with_frame_readout
// Ring of stereo sample blocks between a producer and a frame consumer.
// ----------------------------------------------------------------------------
//  channel | direction | payload | transfer
//  --------+-----------+---------+-------------------------------------------
//  cmd     | in        | cmd_t   | one command: write, commit, frame, resync, mute
//  res     | out       | res_t   | one stereo pair or one mute reply
//
//  after reset a clearing sweep writes zero to the store, all BLOCKS*BLOCK_PAIRS
//  words (864 at the defaults), during which cmd is not ready
//  write, commit, resync and mute commands are taken back to back while res has room
//  a frame request first passes a set-up state that loads the base address,
//  then issues one store read per pair through the shared address unit
//  results leave through a two-entry output queue; a stall on res holds the
//  frame loop and, once the queue is full, cmd
// ----------------------------------------------------------------------------
module audio_block_ring_with_frame_readout #(
	parameter int BLOCKS      = abr_pkg::BLOCKS_DEF,
	parameter int BLOCK_PAIRS = abr_pkg::BLOCK_PAIRS_DEF,
	parameter int FRAME_PAIRS = abr_pkg::FRAME_PAIRS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	abr_stream_if.sink   cmd,
	abr_stream_if.source res
);

	localparam int STORE_WORDS = BLOCKS * BLOCK_PAIRS;
	localparam int AW          = $clog2(STORE_WORDS);
	localparam int AGW         = $clog2(STORE_WORDS + FRAME_PAIRS);
	localparam int QDEPTH      = 2;

	abr_pkg::res_meta_t         issue, meta_s1;
	abr_pkg::agen_ctl_t         agen_ctl;
	logic [AGW-1:0]             agen_load, agen_addr;
	logic                       agen_in_range, agen_at_end;
	logic                       we, room, push, pop;
	logic [AW-1:0]              waddr;
	logic [abr_pkg::WORD_W-1:0] wdata, rdata;
	abr_pkg::res_t              entry;

	abr_pkg::res_t              queue_q [QDEPTH];
	logic                       wptr_q, rptr_q;
	logic [1:0]                 qcnt_q;

	abr_seq #(
		.BLOCKS      (BLOCKS),
		.BLOCK_PAIRS (BLOCK_PAIRS),
		.FRAME_PAIRS (FRAME_PAIRS),
		.AW          (AW),
		.AGW         (AGW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd.valid),
		.cmd           (cmd.data),
		.cmd_ready     (cmd.ready),
		.room          (room),
		.issue         (issue),
		.we            (we),
		.waddr         (waddr),
		.wdata         (wdata),
		.agen_ctl      (agen_ctl),
		.agen_load     (agen_load),
		.agen_addr     (agen_addr),
		.agen_in_range (agen_in_range),
		.agen_at_end   (agen_at_end)
	);

	abr_agen #(
		.LIMIT (STORE_WORDS),
		.AGW   (AGW)
	) u_agen (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (agen_ctl),
		.load_val (agen_load),
		.addr     (agen_addr),
		.in_range (agen_in_range),
		.at_end   (agen_at_end)
	);

	abr_store #(
		.DEPTH (STORE_WORDS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (agen_addr[AW-1:0]),
		.rdata (rdata)
	);

	// slot meta travels alongside the registered store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else begin
			meta_s1 <= issue;
		end
	end

	assign push = meta_s1.valid;
	assign pop  = res.valid && res.ready;

	// queue entries already held or in flight, less the one leaving now
	assign room = (3'({1'b0, qcnt_q}) + 3'(push) - 3'(pop)) < 3'(QDEPTH);

	always_comb begin
		entry.left_out    = meta_s1.use_mem ? rdata[abr_pkg::SAMPLE_W-1:0] : '0;
		entry.right_out   = meta_s1.use_mem ? rdata[abr_pkg::WORD_W-1:abr_pkg::SAMPLE_W] : '0;
		entry.last_of_run = meta_s1.last;
		entry.mute_status = meta_s1.mute_status;
	end

	always_ff @(posedge clk) begin
		if (push) queue_q[wptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			qcnt_q <= '0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			qcnt_q <= qcnt_q + 2'(push) - 2'(pop);
		end
	end

	assign res.valid = qcnt_q != '0;
	assign res.data  = queue_q[rptr_q];

endmodule

// ----- rtl/abr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abr_checker
// Port-level checks on the ring block, bound to the top level.
// ----------------------------------------------------------------------------
module abr_checker (
	input logic          clk,
	input logic          arst_n,
	abr_stream_if.sink   cmd,
	abr_stream_if.source res
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.data))
		else $error("result changed while stalled");

	// a frame request keeps the block busy the cycle after
	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && cmd.data.opcode == abr_pkg::OP_FRAME |=> !cmd.ready)
		else $error("command taken during frame setup");

	// only a mute reply carries a mute status, and it is silent and final
	a_mute_reply: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.mute_status |->
			res.data.last_of_run && res.data.left_out == '0 && res.data.right_out == '0)
		else $error("mute status on a frame pair");

	// clearing sweep runs straight after reset
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !cmd.ready && !res.valid)
		else $error("block active during clearing sweep");

endmodule

bind audio_block_ring_with_frame_readout abr_checker u_abr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.cmd    (cmd),
	.res    (res)
);
